### hw/rtl/spsc_pkg.sv
`timescale 1ns / 1ps
package spsc_pkg;

  localparam int CHANNELS   = 2;
  localparam int SPEED_MAX  = 500;
  localparam int SLOW_SPEED = 10;
  localparam int SLOW_TRIM  = 17;
  localparam int DELAY_MS   = 1000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_NUM_W  = 24;
  localparam int DIV_DEN_W  = 10;

  localparam logic [2:0] FN_TICK   = 3'd0;
  localparam logic [2:0] FN_ACT    = 3'd1;
  localparam logic [2:0] FN_DEACT  = 3'd2;
  localparam logic [2:0] FN_SPEED  = 3'd3;
  localparam logic [2:0] FN_DIRECT = 3'd4;
  localparam logic [2:0] FN_GRAD   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX  = 3'd5;

  localparam logic [3:0] OP_NOP     = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_TICK    = 4'd2;
  localparam logic [3:0] OP_SPD_DIV = 4'd3;
  localparam logic [3:0] OP_SPD_WR  = 4'd4;
  localparam logic [3:0] OP_PLACE   = 4'd5;
  localparam logic [3:0] OP_MUL     = 4'd6;
  localparam logic [3:0] OP_MAP_DIV = 4'd7;
  localparam logic [3:0] OP_MAP_WR  = 4'd8;
  localparam logic [3:0] OP_DEACT   = 4'd9;
  localparam logic [3:0] OP_GRAD    = 4'd10;
  localparam logic [3:0] OP_OUT     = 4'd11;

  typedef struct packed {
    logic [2:0]  func;
    logic        channel;
    logic [7:0]  position;
    logic [15:0] speed;
  } in_t;

  typedef struct packed {
    logic [15:0] first_compare;
    logic [15:0] second_compare;
    logic        first_output_on;
    logic        second_output_on;
    logic [7:0]  first_degrees;
    logic [7:0]  second_degrees;
    logic        first_moving;
    logic        second_moving;
  } out_t;

  typedef struct packed {
    logic [3:0] op;
    logic       ch;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       need_map;
    logic       div_done;
  } dp_sts_t;

endpackage

### hw/rtl/spsc_div.sv
`timescale 1ns / 1ps
module spsc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [spsc_pkg::DIV_NUM_W-1:0]  num,
  input  logic [spsc_pkg::DIV_DEN_W-1:0]  den,
  output logic                            done,
  output logic [spsc_pkg::DIV_NUM_W-1:0]  quo
);

  localparam int NW = spsc_pkg::DIV_NUM_W;
  localparam int DW = spsc_pkg::DIV_DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   sh;
  logic [DW:0]   diff;
  logic          ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    sh       = {rem_r, q_r[NW-1]};
    diff     = sh - {1'b0, den_r};
    ge       = (sh >= {1'b0, den_r});
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (start) begin
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      den_nxt  = den;
      q_nxt    = num;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : sh[DW-1:0];
      q_nxt   = {q_r[NW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

### hw/rtl/spsc_dp.sv
`timescale 1ns / 1ps
module spsc_dp #(
  parameter int SPEED_MAX = spsc_pkg::SPEED_MAX
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  spsc_pkg::dp_cmd_t                cmd,
  output spsc_pkg::dp_sts_t                sts,
  input  spsc_pkg::in_t                    in_data,
  input  logic                             cfg_we,
  input  logic [spsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output spsc_pkg::out_t                   out_data
);

  localparam int CH = spsc_pkg::CHANNELS;
  localparam int NW = spsc_pkg::DIV_NUM_W;
  localparam int DW = spsc_pkg::DIV_DEN_W;

  function automatic logic [7:0] clamp(input logic [7:0] p, input logic [7:0] lo,
                                       input logic [7:0] hi);
    logic [7:0] r;
    r = p;
    if (p < lo) begin
      r = lo;
    end else if (p > hi) begin
      r = hi;
    end
    return r;
  endfunction

  logic [7:0]  lim_min_r [CH];
  logic [7:0]  lim_max_r [CH];
  logic [15:0] pmin_r, pmax_r;
  logic [7:0]  cur_r  [CH];
  logic [7:0]  tgt_r  [CH];
  logic [9:0]  spd_r  [CH];
  logic [15:0] dly_r  [CH];
  logic [15:0] cd_r   [CH];
  logic [15:0] cmp_r  [CH];
  logic        on_r   [CH];
  logic        ramp_r [CH];
  logic        mch_r;
  logic        need_map_r;

  spsc_pkg::in_t  item_r;
  spsc_pkg::out_t out_r;
  logic signed [25:0] prod_r;
  logic signed [8:0]  span_r;
  logic               neg_r;

  logic        ach;
  logic [7:0]  cur_a, tgt_a, lo_a, hi_a;
  logic [9:0]  spd_a, spd_sat;
  logic [15:0] dly_a, cd_a, eff_a, cd1;
  logic [7:0]  pos_cl, step, nxt;
  logic signed [8:0]  dnum, span_in;
  logic signed [16:0] span_out;
  logic [25:0] prod_abs;
  logic [8:0]  span_abs;
  logic [NW-1:0] quo_s;
  logic [15:0] cmp_new;

  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [DW-1:0] div_den;

  always_comb begin
    case (cmd.op)
      spsc_pkg::OP_TICK: ach = cmd.ch;
      spsc_pkg::OP_MUL,
      spsc_pkg::OP_MAP_WR: ach = mch_r;
      default: ach = item_r.channel;
    endcase
  end

  always_comb begin
    cur_a = cur_r[ach];
    tgt_a = tgt_r[ach];
    lo_a  = lim_min_r[ach];
    hi_a  = lim_max_r[ach];
    spd_a = spd_r[ach];
    dly_a = dly_r[ach];
    cd_a  = cd_r[ach];

    spd_sat = (item_r.speed > 16'(SPEED_MAX)) ? 10'(SPEED_MAX)
                                              : item_r.speed[9:0];
    pos_cl  = clamp(item_r.position, lo_a, hi_a);
    eff_a   = (spd_a <= 10'(spsc_pkg::SLOW_SPEED)) ? dly_a - 16'(spsc_pkg::SLOW_TRIM)
                                                   : dly_a;

    cd1 = (cd_a != 16'd0) ? cd_a - 16'd1 : 16'd0;
    if (tgt_a > cur_a) begin
      step = cur_a + 8'd1;
    end else if (tgt_a < cur_a) begin
      step = cur_a - 8'd1;
    end else begin
      step = cur_a;
    end
    nxt = clamp(step, lo_a, hi_a);

    dnum     = $signed({1'b0, cur_a}) - $signed({1'b0, lo_a});
    span_in  = $signed({1'b0, hi_a}) - $signed({1'b0, lo_a});
    span_out = $signed({1'b0, pmax_r}) - $signed({1'b0, pmin_r});

    prod_abs = prod_r[25] ? 26'(-prod_r) : 26'(prod_r);
    span_abs = span_r[8] ? 9'(-span_r) : 9'(span_r);
    quo_s    = neg_r ? NW'(~div_quo + 1'b1) : div_quo;
    cmp_new  = (span_r == 9'sd0) ? pmin_r : quo_s[15:0] + pmin_r;

    div_start = (cmd.op == spsc_pkg::OP_SPD_DIV) || (cmd.op == spsc_pkg::OP_MAP_DIV);
    if (cmd.op == spsc_pkg::OP_MAP_DIV) begin
      div_num = prod_abs[NW-1:0];
      div_den = DW'(span_abs[7:0]);
    end else begin
      div_num = NW'(spsc_pkg::DELAY_MS);
      div_den = spd_sat;
    end
  end

  spsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CH; i++) begin
        lim_min_r[i] <= 8'd0;
        lim_max_r[i] <= 8'd180;
        cur_r[i]     <= '0;
        tgt_r[i]     <= '0;
        spd_r[i]     <= '0;
        dly_r[i]     <= '0;
        cd_r[i]      <= '0;
        cmp_r[i]     <= '0;
        on_r[i]      <= 1'b0;
        ramp_r[i]    <= 1'b0;
      end
      pmin_r     <= 16'd1000;
      pmax_r     <= 16'd2000;
      mch_r      <= 1'b0;
      need_map_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          spsc_pkg::REG_FIRST_MIN:  lim_min_r[0] <= cfg_data[7:0];
          spsc_pkg::REG_FIRST_MAX:  lim_max_r[0] <= cfg_data[7:0];
          spsc_pkg::REG_SECOND_MIN: lim_min_r[1] <= cfg_data[7:0];
          spsc_pkg::REG_SECOND_MAX: lim_max_r[1] <= cfg_data[7:0];
          spsc_pkg::REG_PULSE_MIN:  pmin_r <= cfg_data;
          spsc_pkg::REG_PULSE_MAX:  pmax_r <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        spsc_pkg::OP_TICK: begin
          mch_r      <= ach;
          need_map_r <= ramp_r[ach] && (cd1 == 16'd0);
          if (ramp_r[ach]) begin
            if (cd1 == 16'd0) begin
              cur_r[ach] <= nxt;
              if ((nxt == tgt_a) || (nxt == cur_a)) begin
                ramp_r[ach] <= 1'b0;
                cd_r[ach]   <= cd1;
              end else begin
                cd_r[ach] <= eff_a;
              end
            end else begin
              cd_r[ach] <= cd1;
            end
          end
        end
        spsc_pkg::OP_SPD_WR: begin
          spd_r[ach] <= spd_sat;
          dly_r[ach] <= (spd_sat == 10'd0) ? 16'hFFFF : div_quo[15:0];
        end
        spsc_pkg::OP_PLACE: begin
          mch_r       <= ach;
          cur_r[ach]  <= pos_cl;
          tgt_r[ach]  <= pos_cl;
          ramp_r[ach] <= 1'b0;
          if (item_r.func == spsc_pkg::FN_ACT) begin
            on_r[ach] <= 1'b1;
          end
        end
        spsc_pkg::OP_MAP_WR: cmp_r[ach] <= cmp_new;
        spsc_pkg::OP_DEACT: begin
          on_r[ach]   <= 1'b0;
          cmp_r[ach]  <= 16'd0;
          ramp_r[ach] <= 1'b0;
        end
        spsc_pkg::OP_GRAD: begin
          tgt_r[ach] <= pos_cl;
          if (pos_cl != cur_a) begin
            ramp_r[ach] <= 1'b1;
            cd_r[ach]   <= eff_a;
          end else begin
            ramp_r[ach] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      spsc_pkg::OP_LOAD: item_r <= in_data;
      spsc_pkg::OP_MUL: begin
        prod_r <= 26'(dnum) * 26'(span_out);
        span_r <= span_in;
      end
      spsc_pkg::OP_MAP_DIV: neg_r <= prod_r[25] ^ span_r[8];
      spsc_pkg::OP_OUT: begin
        out_r.first_compare    <= cmp_r[0];
        out_r.second_compare   <= cmp_r[1];
        out_r.first_output_on  <= on_r[0];
        out_r.second_output_on <= on_r[1];
        out_r.first_degrees    <= cur_r[0];
        out_r.second_degrees   <= cur_r[1];
        out_r.first_moving     <= ramp_r[0];
        out_r.second_moving    <= ramp_r[1];
      end
      default: ;
    endcase
  end

  assign sts.func     = item_r.func;
  assign sts.need_map = need_map_r;
  assign sts.div_done = div_done;
  assign out_data     = out_r;

endmodule

### hw/rtl/spsc_ctrl.sv
`timescale 1ns / 1ps
module spsc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  spsc_pkg::dp_sts_t  sts,
  output spsc_pkg::dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_TICK  = 4'd2;
  localparam logic [3:0] S_TCHK  = 4'd3;
  localparam logic [3:0] S_SPD   = 4'd4;
  localparam logic [3:0] S_SPDW  = 4'd5;
  localparam logic [3:0] S_PLACE = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_MDIV  = 4'd8;
  localparam logic [3:0] S_MDW   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       tick_ch_r, tick_ch_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    tick_ch_nxt   = tick_ch_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = spsc_pkg::OP_NOP;
    cmd.ch        = tick_ch_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = spsc_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        tick_ch_nxt = 1'b0;
        case (sts.func)
          spsc_pkg::FN_TICK:   state_nxt = S_TICK;
          spsc_pkg::FN_ACT,
          spsc_pkg::FN_SPEED:  state_nxt = S_SPD;
          spsc_pkg::FN_DEACT: begin
            cmd.op    = spsc_pkg::OP_DEACT;
            state_nxt = S_OUT;
          end
          spsc_pkg::FN_DIRECT: state_nxt = S_PLACE;
          spsc_pkg::FN_GRAD: begin
            cmd.op    = spsc_pkg::OP_GRAD;
            state_nxt = S_OUT;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_TICK: begin
        cmd.op    = spsc_pkg::OP_TICK;
        state_nxt = S_TCHK;
      end
      S_TCHK: begin
        if (sts.need_map) begin
          state_nxt = S_MUL;
        end else if (!tick_ch_r) begin
          tick_ch_nxt = 1'b1;
          state_nxt   = S_TICK;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SPD: begin
        cmd.op    = spsc_pkg::OP_SPD_DIV;
        state_nxt = S_SPDW;
      end
      S_SPDW: begin
        if (sts.div_done) begin
          cmd.op    = spsc_pkg::OP_SPD_WR;
          state_nxt = (sts.func == spsc_pkg::FN_ACT) ? S_PLACE : S_OUT;
        end
      end
      S_PLACE: begin
        cmd.op    = spsc_pkg::OP_PLACE;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = spsc_pkg::OP_MUL;
        state_nxt = S_MDIV;
      end
      S_MDIV: begin
        cmd.op    = spsc_pkg::OP_MAP_DIV;
        state_nxt = S_MDW;
      end
      S_MDW: begin
        if (sts.div_done) begin
          cmd.op = spsc_pkg::OP_MAP_WR;
          if ((sts.func == spsc_pkg::FN_TICK) && !tick_ch_r) begin
            tick_ch_nxt = 1'b1;
            state_nxt   = S_TICK;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = spsc_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_ch_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_ch_r   <= tick_ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### hw/rtl/servo_position_slew_controller.sv
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// in_       input      in_valid / in_ready    in_data   (command item)
// out_      output     out_valid / out_ready  out_data  (state of both channels)
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item at a time; activate, speed and a tick that steps a channel
// wait on the shared divider
// reset: synchronous active low, limits 0..180, pulse range 1000..2000
// a finished result waits in the output register, the next item is taken meanwhile
// cfg_ready is always high
module servo_position_slew_controller #(
  parameter int SPEED_MAX = spsc_pkg::SPEED_MAX
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  spsc_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output spsc_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  spsc_pkg::dp_cmd_t cmd;
  spsc_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  spsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spsc_dp #(
    .SPEED_MAX (SPEED_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result posted without returning to idle");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import spsc_pkg::*;

  localparam logic [2:0] FN_RSVD_LO = 3'd6;
  localparam logic [2:0] FN_RSVD_HI = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  servo_position_slew_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // servo state as the block should hold it
  logic [7:0]  cur_deg [2];
  logic [7:0]  tgt_deg [2];
  logic [7:0]  lim_lo  [2];
  logic [7:0]  lim_hi  [2];
  logic [9:0]  spd_val [2];
  logic [15:0] step_dly[2];
  logic [15:0] count_dn[2];
  logic [15:0] cmp_val [2];
  logic [15:0] pw_lo;
  logic [15:0] pw_hi;
  bit          out_on  [2];
  bit          moving  [2];

  in_t  cmd_q[$];
  out_t state_q[$];
  int   queued;
  int   mismatches;
  bit   in_took;

  function automatic void reset_servo_model();
    for (int ch = 0; ch < CHANNELS; ch++) begin
      cur_deg[ch]  = '0;
      tgt_deg[ch]  = '0;
      spd_val[ch]  = '0;
      step_dly[ch] = '0;
      count_dn[ch] = '0;
      cmp_val[ch]  = '0;
      out_on[ch]   = 1'b0;
      moving[ch]   = 1'b0;
      lim_lo[ch]   = 8'd0;
      lim_hi[ch]   = 8'd180;
    end
    pw_lo = 16'd1000;
    pw_hi = 16'd2000;
  endfunction

  function automatic logic [7:0] clamp_deg(int ch, logic [7:0] p);
    if (p < lim_lo[ch]) return lim_lo[ch];
    if (p > lim_hi[ch]) return lim_hi[ch];
    return p;
  endfunction

  function automatic logic [15:0] deg_to_count(int ch, logic [7:0] p);
    longint pv, lo, hi, plo, phi, span_in, r;
    pv  = p;
    lo  = lim_lo[ch];
    hi  = lim_hi[ch];
    plo = pw_lo;
    phi = pw_hi;
    span_in = hi - lo;
    if (span_in == 0) return pw_lo;
    r = (pv - lo) * (phi - plo) / span_in + plo;
    return r[15:0];
  endfunction

  function automatic void load_speed(int ch, logic [15:0] s);
    int unsigned v;
    v = s;
    if (v > SPEED_MAX) v = SPEED_MAX;
    spd_val[ch]  = v[9:0];
    step_dly[ch] = (v == 0) ? 16'hFFFF : 16'(DELAY_MS / v);
  endfunction

  function automatic logic [15:0] reload_delay(int ch);
    logic [15:0] d;
    d = step_dly[ch];
    if (spd_val[ch] <= SLOW_SPEED) d = d - 16'(SLOW_TRIM);
    return d;
  endfunction

  function automatic void move_to(int ch, logic [7:0] p);
    cur_deg[ch] = p;
    cmp_val[ch] = deg_to_count(ch, p);
  endfunction

  function automatic void step_ramp(int ch);
    logic [7:0] now_deg, nxt;
    if (!moving[ch]) return;
    if (count_dn[ch] != 0) count_dn[ch] = count_dn[ch] - 16'd1;
    if (count_dn[ch] != 0) return;
    now_deg = cur_deg[ch];
    if (tgt_deg[ch] > now_deg) nxt = now_deg + 8'd1;
    else if (tgt_deg[ch] < now_deg) nxt = now_deg - 8'd1;
    else nxt = now_deg;
    nxt = clamp_deg(ch, nxt);
    move_to(ch, nxt);
    if (nxt == tgt_deg[ch] || nxt == now_deg) moving[ch] = 1'b0;
    else count_dn[ch] = reload_delay(ch);
  endfunction

  function automatic out_t servo_step(in_t cmd);
    out_t       r;
    logic [7:0] p;
    int         ch;
    ch = cmd.channel;
    case (cmd.func)
      FN_TICK: begin
        step_ramp(0);
        step_ramp(1);
      end
      FN_ACT: begin
        load_speed(ch, cmd.speed);
        p = clamp_deg(ch, cmd.position);
        move_to(ch, p);
        tgt_deg[ch] = p;
        out_on[ch]  = 1'b1;
        moving[ch]  = 1'b0;
      end
      FN_DEACT: begin
        out_on[ch]  = 1'b0;
        cmp_val[ch] = '0;
        moving[ch]  = 1'b0;
      end
      FN_SPEED: load_speed(ch, cmd.speed);
      FN_DIRECT: begin
        p = clamp_deg(ch, cmd.position);
        move_to(ch, p);
        tgt_deg[ch] = p;
        moving[ch]  = 1'b0;
      end
      FN_GRAD: begin
        p = clamp_deg(ch, cmd.position);
        tgt_deg[ch] = p;
        if (p != cur_deg[ch]) begin
          moving[ch]   = 1'b1;
          count_dn[ch] = reload_delay(ch);
        end else begin
          moving[ch] = 1'b0;
        end
      end
      default: ;
    endcase
    r.first_compare    = cmp_val[0];
    r.second_compare   = cmp_val[1];
    r.first_output_on  = out_on[0];
    r.second_output_on = out_on[1];
    r.first_degrees    = cur_deg[0];
    r.second_degrees   = cur_deg[1];
    r.first_moving     = moving[0];
    r.second_moving    = moving[1];
    return r;
  endfunction

  task automatic report(string field, longint want, longint got);
    $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    mismatches++;
  endtask

  task automatic check_state(out_t want, out_t got);
    if (got.first_compare !== want.first_compare)
      report("first_compare", want.first_compare, got.first_compare);
    if (got.second_compare !== want.second_compare)
      report("second_compare", want.second_compare, got.second_compare);
    if (got.first_output_on !== want.first_output_on)
      report("first_output_on", want.first_output_on, got.first_output_on);
    if (got.second_output_on !== want.second_output_on)
      report("second_output_on", want.second_output_on, got.second_output_on);
    if (got.first_degrees !== want.first_degrees)
      report("first_degrees", want.first_degrees, got.first_degrees);
    if (got.second_degrees !== want.second_degrees)
      report("second_degrees", want.second_degrees, got.second_degrees);
    if (got.first_moving !== want.first_moving)
      report("first_moving", want.first_moving, got.first_moving);
    if (got.second_moving !== want.second_moving)
      report("second_moving", want.second_moving, got.second_moving);
  endtask

  // monitor
  always @(posedge clk) begin
    in_took = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (state_q.size() == 0) begin
        $display("%0t: result with no item pending, got %h", $time, out_data);
        mismatches++;
      end else begin
        check_state(state_q.pop_front(), out_data);
      end
    end
    if (in_took) state_q.push_back(servo_step(in_data));
  end

  // command driver, bursts with gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= cmd_q.pop_front();
        if (burst_left <= 1) begin
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(10, 40);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = $urandom_range(1, 10);
          end
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver stalls
  int   ready_left = 0;
  logic ready_lvl  = 1'b1;

  always @(negedge clk) begin
    int pick;
    if (ready_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        ready_lvl  = 1'b1;
        ready_left = $urandom_range(1, 40);
      end else if (pick < 8) begin
        ready_lvl  = 1'b0;
        ready_left = $urandom_range(1, 6);
      end else begin
        ready_lvl  = 1'b0;
        ready_left = $urandom_range(20, 40);
      end
    end else begin
      ready_left--;
    end
    out_ready <= ready_lvl;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FIRST_MIN:  lim_lo[0] = val[7:0];
      REG_FIRST_MAX:  lim_hi[0] = val[7:0];
      REG_SECOND_MIN: lim_lo[1] = val[7:0];
      REG_SECOND_MAX: lim_hi[1] = val[7:0];
      REG_PULSE_MIN:  pw_lo     = val;
      REG_PULSE_MAX:  pw_hi     = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup_limits(logic [7:0] lo0, logic [7:0] hi0, logic [7:0] lo1,
                              logic [7:0] hi1, logic [15:0] plo, logic [15:0] phi);
    write_reg(REG_FIRST_MIN, {8'd0, lo0});
    write_reg(REG_FIRST_MAX, {8'd0, hi0});
    write_reg(REG_SECOND_MIN, {8'd0, lo1});
    write_reg(REG_SECOND_MAX, {8'd0, hi1});
    write_reg(REG_PULSE_MIN, plo);
    write_reg(REG_PULSE_MAX, phi);
    end_writes();
  endtask

  task automatic shuffle_setup();
    logic [7:0] a [4];
    for (int i = 0; i < 4; i += 2) begin
      a[i]   = 8'($urandom);
      a[i+1] = 8'($urandom);
      if ($urandom_range(0, 3) != 0 && a[i] > a[i+1]) {a[i], a[i+1]} = {a[i+1], a[i]};
    end
    setup_limits(a[0], a[1], a[2], a[3], 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_idle();
    while (!(cmd_q.size() == 0 && !in_valid && state_q.size() == 0)) @(negedge clk);
  endtask

  function automatic void queue_item(in_t c);
    cmd_q.push_back(c);
    if (c.func <= FN_GRAD) queued++;
  endfunction

  function automatic void queue_cmd(logic [2:0] func, logic ch, logic [7:0] pos,
                                    logic [15:0] spd);
    in_t c;
    c.func     = func;
    c.channel  = ch;
    c.position = pos;
    c.speed    = spd;
    queue_item(c);
  endfunction

  function automatic in_t noise_cmd();
    in_t c;
    int  pick;
    pick = $urandom_range(0, 19);
    if (pick < 6) c.func = FN_TICK;
    else if (pick < 9) c.func = FN_ACT;
    else if (pick < 11) c.func = FN_DEACT;
    else if (pick < 13) c.func = FN_SPEED;
    else if (pick < 15) c.func = FN_DIRECT;
    else if (pick < 18) c.func = FN_GRAD;
    else if (pick == 18) c.func = FN_RSVD_LO;
    else c.func = FN_RSVD_HI;
    c.channel = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick == 0) c.position = 8'd0;
    else if (pick == 1) c.position = 8'd255;
    else c.position = 8'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 4) c.speed = 16'($urandom);
    else if (pick < 6) c.speed = 16'($urandom_range(0, 10));
    else if (pick == 6) c.speed = 16'hFFFF;
    else c.speed = 16'($urandom_range(11, 500));
    return c;
  endfunction

  // often set speed, place, then ramp up to 8 degrees and tick through part of it
  task automatic add_scene();
    logic       ch;
    logic [7:0] p;
    int         s, d, tgt, n, pick;
    ch   = 1'($urandom_range(0, 1));
    p    = 8'($urandom);
    s    = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 99) : $urandom_range(100, 500);
    pick = $urandom_range(0, 3);
    if (pick == 0) queue_cmd(FN_ACT, ch, p, 16'(s));
    else if (pick < 3) queue_cmd(FN_SPEED, ch, p, 16'(s));
    queue_cmd(FN_DIRECT, ch, p, 16'($urandom));
    d   = $urandom_range(0, 8);
    tgt = ($urandom_range(0, 1) == 0) ? p + d : p - d;
    if (tgt < 0) tgt = 0;
    if (tgt > 255) tgt = 255;
    queue_cmd(FN_GRAD, ch, 8'(tgt), 16'($urandom));
    n = $urandom_range(0, d * (1000 / s) + 4);
    if (n > 60) n = 60;
    repeat (n) begin
      if ($urandom_range(0, 6) == 0) queue_item(noise_cmd());
      else queue_cmd(FN_TICK, 1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom));
    end
  endtask

  // random items, then leave both channels ramping into the next setup
  task automatic run_random(int n);
    queued = 0;
    while (queued < n) begin
      if ($urandom_range(0, 9) < 6) add_scene();
      else queue_item(noise_cmd());
    end
    queue_cmd(FN_SPEED, 1'b0, 8'd0, 16'd500);
    queue_cmd(FN_GRAD, 1'b0, 8'($urandom), 16'd0);
    queue_cmd(FN_SPEED, 1'b1, 8'd0, 16'd250);
    queue_cmd(FN_GRAD, 1'b1, 8'($urandom), 16'd0);
    queue_cmd(FN_TICK, 1'b0, 8'd0, 16'd0);
    wait_idle();
  endtask

  initial begin
    mismatches = 0;
    reset_servo_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_cmd(FN_TICK, 1'b0, 8'd0, 16'd0);
    queue_cmd(FN_GRAD, 1'b0, 8'd20, 16'd0);
    queue_cmd(FN_TICK, 1'b1, 8'd0, 16'd0);
    queue_cmd(FN_ACT, 1'b0, 8'd255, 16'hFFFF);
    queue_cmd(FN_ACT, 1'b1, 8'd0, 16'd0);
    queue_cmd(FN_SPEED, 1'b1, 8'd0, 16'd500);
    queue_cmd(FN_GRAD, 1'b1, 8'd3, 16'd0);
    repeat (6) queue_cmd(FN_TICK, 1'b0, 8'd0, 16'd0);
    queue_cmd(FN_SPEED, 1'b0, 8'd0, 16'd10);
    queue_cmd(FN_SPEED, 1'b0, 8'd0, 16'd11);
    queue_cmd(FN_SPEED, 1'b0, 8'd0, 16'd1);
    queue_cmd(FN_GRAD, 1'b0, 8'd179, 16'd0);
    queue_cmd(FN_DIRECT, 1'b0, 8'd90, 16'd0);
    queue_cmd(FN_GRAD, 1'b0, 8'd90, 16'd0);
    queue_cmd(FN_DEACT, 1'b0, 8'd0, 16'd0);
    queue_cmd(FN_DIRECT, 1'b0, 8'd45, 16'd0);
    queue_cmd(FN_GRAD, 1'b0, 8'd0, 16'd0);
    queue_cmd(FN_RSVD_LO, 1'b1, 8'd255, 16'hFFFF);
    queue_cmd(FN_RSVD_HI, 1'b0, 8'd0, 16'd0);
    queue_cmd(FN_DEACT, 1'b1, 8'd0, 16'd0);
    wait_idle();

    run_random(80);
    setup_limits(8'd0, 8'd255, 8'd0, 8'd255, 16'd0, 16'hFFFF);
    run_random(90);
    setup_limits(8'd200, 8'd50, 8'd10, 8'd170, 16'hFFFF, 16'd0);
    run_random(90);
    setup_limits(8'd90, 8'd90, 8'd255, 8'd255, 16'd1500, 16'd1500);
    run_random(80);
    setup_limits(8'd30, 8'd60, 8'd0, 8'd0, 16'd500, 16'd2500);
    run_random(80);
    repeat (3) begin
      shuffle_setup();
      run_random(80);
    end
    setup_limits(8'd0, 8'd180, 8'd0, 8'd180, 16'd1000, 16'd2000);
    run_random(80);

    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("** servo_position_slew_controller: PASSED **");
    end else begin
      $display("** servo_position_slew_controller: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** servo_position_slew_controller: FAILED **");
    $finish;
  end

endmodule

### sim.f
hw/rtl/spsc_pkg.sv
hw/rtl/spsc_div.sv
hw/rtl/spsc_dp.sv
hw/rtl/spsc_ctrl.sv
hw/rtl/servo_position_slew_controller.sv
verif/tb.sv
